// ===== rtl/arsc_pkg.sv =====
// arsc_pkg: shared types and constants for the remote switch code sender.
// Used by every module under rtl/; depends on nothing else.
package arsc_pkg;

    // transaction payloads
    typedef struct packed {
        logic        operation;
        logic        switch_on;
        logic [31:0] code;
    } in_item_t;

    typedef struct packed {
        logic       carrier_on;
        logic [7:0] period_preload;
        logic       preload_valid;
        logic       finished;
    } out_item_t;

    // configuration register file contents
    typedef struct packed {
        logic [7:0] short_preload;
        logic [7:0] long_preload;
        logic [7:0] pause_preload;
        logic [7:0] repeat_limit;
    } cfg_t;

    // result from the step logic toward the output register
    typedef struct packed {
        logic      valid;
        out_item_t data;
    } res_slot_t;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // register indexes
    localparam logic [1:0] REG_SHORT_PRELOAD = 2'd0;
    localparam logic [1:0] REG_LONG_PRELOAD  = 2'd1;
    localparam logic [1:0] REG_PAUSE_PRELOAD = 2'd2;
    localparam logic [1:0] REG_REPEAT_LIMIT  = 2'd3;

    // register reset values
    localparam logic [7:0] SHORT_PRELOAD_RST = 8'd205;
    localparam logic [7:0] LONG_PRELOAD_RST  = 8'd155;
    localparam logic [7:0] PAUSE_PRELOAD_RST = 8'd130;
    localparam logic [7:0] REPEAT_LIMIT_RST  = 8'd120;

    // code word marks
    localparam logic [31:0] ON_MARK  = 32'h0000_0100;
    localparam logic [31:0] OFF_MARK = 32'h0000_0400;

    // bit walk positions (one-hot mask kept as its bit index)
    localparam logic [4:0] TOP_POS      = 5'd31;
    localparam logic [4:0] CODE_END_POS = 5'd8;   // lowest transmitted code bit
    localparam logic [4:0] TRAIL_POS    = 5'd7;   // trailing on pulse
    localparam logic [4:0] LAST_POS     = 5'd0;

endpackage

// ===== rtl/arsc_cfg_regs.sv =====
// arsc_cfg_regs: the four 8-bit configuration registers and their write port.
// Depends on arsc_pkg.
module arsc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata,
    output arsc_pkg::cfg_t      cfg
);

    arsc_pkg::cfg_t cfg_reg;
    arsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                arsc_pkg::REG_SHORT_PRELOAD: cfg_next.short_preload = cfg_wdata;
                arsc_pkg::REG_LONG_PRELOAD:  cfg_next.long_preload  = cfg_wdata;
                arsc_pkg::REG_PAUSE_PRELOAD: cfg_next.pause_preload = cfg_wdata;
                arsc_pkg::REG_REPEAT_LIMIT:  cfg_next.repeat_limit  = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_preload <= arsc_pkg::SHORT_PRELOAD_RST;
            cfg_reg.long_preload  <= arsc_pkg::LONG_PRELOAD_RST;
            cfg_reg.pause_preload <= arsc_pkg::PAUSE_PRELOAD_RST;
            cfg_reg.repeat_limit  <= arsc_pkg::REPEAT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/arsc_step_core.sv =====
// arsc_step_core: sender state (code, repeat count, bit walk) and the
// combinational step logic for one transaction. Depends on arsc_pkg.
module arsc_step_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  arsc_pkg::in_item_t   item,
    input  arsc_pkg::cfg_t       cfg,
    output arsc_pkg::res_slot_t  slot
);

    logic [31:0] code_reg,    code_next;
    logic [7:0]  repeats_reg, repeats_next;
    logic [4:0]  pos_reg,     pos_next;
    logic        half_reg,    half_next;
    logic        armed_reg,   armed_next;

    logic [4:0]  pos_eff;
    logic        half_eff;
    logic        code_bit;
    logic        carrier;
    logic [7:0]  preload;
    logic        half_new;

    always_comb
    begin
        code_next    = code_reg;
        repeats_next = repeats_reg;
        pos_next     = pos_reg;
        half_next    = half_reg;
        armed_next   = armed_reg;
        slot         = '0;

        // arming restarts the walk at the top bit
        pos_eff  = armed_reg ? pos_reg  : arsc_pkg::TOP_POS;
        half_eff = armed_reg ? half_reg : 1'b0;
        code_bit = code_reg[pos_eff];
        carrier  = 1'b0;
        preload  = cfg.pause_preload;
        half_new = ~half_eff;

        if (pos_eff >= arsc_pkg::CODE_END_POS)
        begin
            // one: long then short; zero: short then long
            carrier  = ~half_eff;
            preload  = (code_bit ^ half_eff) ? cfg.long_preload : cfg.short_preload;
            half_new = ~half_eff;
        end
        else if (pos_eff == arsc_pkg::TRAIL_POS)
        begin
            carrier  = 1'b1;
            preload  = cfg.short_preload;
            half_new = 1'b0;
        end

        if (fire)
        begin
            if (item.operation == arsc_pkg::OP_SEND)
            begin
                code_next    = item.code |
                               (item.switch_on ? arsc_pkg::ON_MARK : arsc_pkg::OFF_MARK);
                repeats_next = '0;
            end
            else if (repeats_reg == cfg.repeat_limit)
            begin
                // final tick: carrier off, stop
                repeats_next             = repeats_reg + 8'd1;
                armed_next               = 1'b0;
                pos_next                 = pos_eff;
                half_next                = half_eff;
                slot.valid               = 1'b1;
                slot.data.carrier_on     = 1'b0;
                slot.data.period_preload = '0;
                slot.data.preload_valid  = 1'b0;
                slot.data.finished       = 1'b1;
            end
            else if (repeats_reg < cfg.repeat_limit)
            begin
                armed_next = 1'b1;
                half_next  = half_new;
                pos_next   = pos_eff;
                if (!half_new)
                begin
                    if (pos_eff == arsc_pkg::LAST_POS)
                    begin
                        // block done
                        repeats_next = repeats_reg + 8'd1;
                        pos_next     = arsc_pkg::TOP_POS;
                    end
                    else
                    begin
                        pos_next = pos_eff - 5'd1;
                    end
                end
                slot.valid               = 1'b1;
                slot.data.carrier_on     = carrier;
                slot.data.period_preload = preload;
                slot.data.preload_valid  = 1'b1;
                slot.data.finished       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg    <= '0;
            repeats_reg <= '0;
            pos_reg     <= arsc_pkg::TOP_POS;
            half_reg    <= 1'b0;
            armed_reg   <= 1'b0;
        end
        else
        begin
            code_reg    <= code_next;
            repeats_reg <= repeats_next;
            pos_reg     <= pos_next;
            half_reg    <= half_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

// ===== rtl/arsc_out_reg.sv =====
// arsc_out_reg: result register on the output channel; frees itself when the
// consumer takes the transaction. Depends on arsc_pkg.
module arsc_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arsc_pkg::res_slot_t  slot,
    input  logic                 result_stall,
    output logic                 ready,
    output logic                 result_valid,
    output arsc_pkg::out_item_t  result
);

    logic                valid_reg, valid_next;
    arsc_pkg::out_item_t data_reg;

    assign ready      = !valid_reg || !result_stall;
    assign valid_next = ready ? slot.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && slot.valid)
        begin
            data_reg <= slot.data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ===== rtl/ask_remote_switch_code_sender_unit.sv =====
// ask_remote_switch_code_sender_unit: top level of the on-off-keyed remote
// switch code sender. Depends on arsc_pkg, arsc_cfg_regs, arsc_step_core, arsc_out_reg.
//
// A send transaction (operation = 1) stores the 32-bit code with bit 8 (on) or
// bit 10 (off) set and restarts the repeat count; it gives no result. Each tick
// transaction (operation = 0) advances the bit walk from bit 31 down to bit 8,
// every bit sent as a carrier-on half and a carrier-off half (one: long/short,
// zero: short/long), then a short trailing on pulse and a 14-tick off pause.
// Each tick gives one result: carrier state and the timer preload for the next
// period. The block repeats repeat_limit times; the tick after the last block
// gives a finished result with the carrier off, and later ticks give nothing
// until the next send. Timing: one transaction per cycle sustained unless
// result_stall holds the result register; a tick's result goes from the input
// register through the step logic into the result register, which presents
// it. The combinational step logic sets the rate. item_stall rises only when the
// input register is full and the result register is held by result_stall.
// Configuration registers may be written when idle.
module ask_remote_switch_code_sender_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  arsc_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output arsc_pkg::out_item_t  result,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata
);

    arsc_pkg::cfg_t      cfg;
    arsc_pkg::res_slot_t slot;
    arsc_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg, in_valid_next;
    logic                out_ready;
    logic                advance;
    logic                take;

    // input register: holds one transaction until the step logic can run
    assign advance       = in_valid_reg && out_ready;
    assign item_stall    = in_valid_reg && !out_ready;
    assign take          = item_valid && !item_stall;
    assign in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item;
        end
    end

    arsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    arsc_step_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .slot  (slot)
    );

    arsc_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot),
        .result_stall (result_stall),
        .ready        (out_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    // stall only with a transaction parked in the input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !item_stall)
        else $error("item_stall with empty input register");

    // a send never produces a result
    a_send_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.operation == arsc_pkg::OP_SEND) |-> !slot.valid)
        else $error("send transaction produced a result");

    // finished result turns the carrier off and loads no preload
    a_finish_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.finished) |-> (!result.carrier_on && !result.preload_valid))
        else $error("malformed finished result");

    // every other result carries a preload
    a_tick_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.finished) |-> result.preload_valid)
        else $error("tick result without preload");

endmodule
